### rtl/fdma_pkg.sv
package fdma_pkg;

    localparam int FRAME_DIM_W     = 11;
    localparam int WINDOW_HALF_W   = 10;
    localparam int THRESHOLD_W     = 8;
    localparam int PIXEL_W         = 8;
    localparam int CFG_INDEX_W     = 2;
    localparam int CFG_DATA_W      = 11;

    localparam int MAX_FRAME_PIXELS_DEF = 524288;
    localparam int COORD_BITS_DEF       = 10;

    localparam int WORK_QUEUE_DEPTH   = 4;
    localparam int RESULT_QUEUE_DEPTH = 2;

    localparam logic [FRAME_DIM_W-1:0]   FRAME_WIDTH_RST    = 11'd640;
    localparam logic [FRAME_DIM_W-1:0]   FRAME_HEIGHT_RST   = 11'd480;
    localparam logic [WINDOW_HALF_W-1:0] WINDOW_HALF_RST    = 10'd200;
    localparam logic [THRESHOLD_W-1:0]   DIFF_THRESHOLD_RST = 8'd140;

    localparam logic CMD_PIXEL   = 1'b0;
    localparam logic CMD_SILENCE = 1'b1;

    localparam logic [CFG_INDEX_W-1:0] REG_FRAME_WIDTH    = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_FRAME_HEIGHT   = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_WINDOW_HALF    = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_DIFF_THRESHOLD = 2'd3;

    typedef struct packed {
        logic               cmd;
        logic [PIXEL_W-1:0] gray_level;
    } t_in_item;

    typedef struct packed {
        logic motion;
        logic alarm_on;
        logic alarm_started;
    } t_out_item;

    typedef struct packed {
        logic               silence;
        logic               check;
        logic               last;
        logic               report;
        logic [PIXEL_W-1:0] gray_level;
    } t_token;

    typedef struct packed {
        t_token             tok;
        logic [PIXEL_W-1:0] old_level;
    } t_work;

endpackage

### rtl/frame_diff_motion_alarm.sv
// Path: a result beat for the last pixel of a compared frame passes the store stage, the
// work queue and the back stage into the result queue; silence beats and other pixels give no result.
// Throughput: one input beat per cycle, set by the single read and write of the frame
// store per pixel; full rises only when the work queue or the result queue backs up.
// Reset is synchronous and active low; the frame store is not cleared and the first frame
// after reset or after a geometry write only fills it.
module frame_diff_motion_alarm #(
    parameter int MAX_FRAME_PIXELS = fdma_pkg::MAX_FRAME_PIXELS_DEF,
    parameter int COORD_BITS       = fdma_pkg::COORD_BITS_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               push,
    output logic                               full,
    input  fdma_pkg::t_in_item                 i_in,
    output logic                               empty,
    input  logic                               pop,
    output fdma_pkg::t_out_item                o_out,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [fdma_pkg::CFG_INDEX_W-1:0]   i_cfg_index,
    input  logic [fdma_pkg::CFG_DATA_W-1:0]    i_cfg_data
);

    localparam int AddrW = $clog2(MAX_FRAME_PIXELS);

    logic [fdma_pkg::FRAME_DIM_W-1:0]   r_frame_width, r_frame_height;
    logic [fdma_pkg::WINDOW_HALF_W-1:0] r_window_half;
    logic [fdma_pkg::THRESHOLD_W-1:0]   r_diff_threshold;

    logic                cfg_write, restart, accept;
    fdma_pkg::t_token    tok;
    logic                store;
    logic [AddrW-1:0]    addr;
    logic                work_valid, work_full, work_empty, work_pop;
    fdma_pkg::t_work     work_in, work_out;
    logic                res_push, res_full;
    fdma_pkg::t_out_item res_in;

    assign o_cfg_ready = 1'b1;
    assign cfg_write   = i_cfg_valid;
    assign restart     = cfg_write && ((i_cfg_index == fdma_pkg::REG_FRAME_WIDTH) ||
                                       (i_cfg_index == fdma_pkg::REG_FRAME_HEIGHT));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width    <= fdma_pkg::FRAME_WIDTH_RST;
            r_frame_height   <= fdma_pkg::FRAME_HEIGHT_RST;
            r_window_half    <= fdma_pkg::WINDOW_HALF_RST;
            r_diff_threshold <= fdma_pkg::DIFF_THRESHOLD_RST;
        end else if (cfg_write) begin
            case (i_cfg_index)
                fdma_pkg::REG_FRAME_WIDTH: begin
                    r_frame_width <= i_cfg_data;
                end
                fdma_pkg::REG_FRAME_HEIGHT: begin
                    r_frame_height <= i_cfg_data;
                end
                fdma_pkg::REG_WINDOW_HALF: begin
                    r_window_half <= i_cfg_data[fdma_pkg::WINDOW_HALF_W-1:0];
                end
                fdma_pkg::REG_DIFF_THRESHOLD: begin
                    r_diff_threshold <= i_cfg_data[fdma_pkg::THRESHOLD_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    assign full   = work_full;
    assign accept = push && !work_full;

    fdma_front #(
        .MAX_FRAME_PIXELS (MAX_FRAME_PIXELS),
        .COORD_BITS       (COORD_BITS)
    ) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_accept       (accept),
        .i_item         (i_in),
        .i_restart      (restart),
        .i_frame_width  (r_frame_width),
        .i_frame_height (r_frame_height),
        .i_window_half  (r_window_half),
        .o_tok          (tok),
        .o_store        (store),
        .o_addr         (addr)
    );

    fdma_store #(
        .MAX_FRAME_PIXELS (MAX_FRAME_PIXELS)
    ) u_store (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_issue (accept),
        .i_tok   (tok),
        .i_store (store),
        .i_addr  (addr),
        .o_valid (work_valid),
        .o_work  (work_in)
    );

    // One slot is held back for the beat still in the store stage.
    fdma_fifo #(
        .t_data (fdma_pkg::t_work),
        .DEPTH  (fdma_pkg::WORK_QUEUE_DEPTH),
        .SLACK  (1)
    ) u_work_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (work_valid),
        .i_data  (work_in),
        .o_full  (work_full),
        .i_pop   (work_pop),
        .o_data  (work_out),
        .o_empty (work_empty)
    );

    fdma_back u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_restart        (restart),
        .i_diff_threshold (r_diff_threshold),
        .i_work_empty     (work_empty),
        .i_work           (work_out),
        .o_work_pop       (work_pop),
        .i_res_full       (res_full),
        .o_res_push       (res_push),
        .o_res            (res_in)
    );

    fdma_fifo #(
        .t_data (fdma_pkg::t_out_item),
        .DEPTH  (fdma_pkg::RESULT_QUEUE_DEPTH),
        .SLACK  (0)
    ) u_res_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_push),
        .i_data  (res_in),
        .o_full  (res_full),
        .i_pop   (pop),
        .o_data  (o_out),
        .o_empty (empty)
    );

endmodule

### rtl/fdma_fifo.sv
module fdma_fifo #(
    parameter type t_data = logic,
    parameter int  DEPTH  = 4,
    parameter int  SLACK  = 0
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_data i_data,
    output logic  o_full,
    input  logic  i_pop,
    output t_data o_data,
    output logic  o_empty
);

    localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CntW = $clog2(DEPTH + 1);

    t_data            r_mem [DEPTH];
    logic [PtrW-1:0]  r_wr, r_rd, n_wr, n_rd;
    logic [CntW-1:0]  r_count, n_count;
    logic             do_push, do_pop;

    assign do_push = i_push && (r_count != CntW'(DEPTH));
    assign do_pop  = i_pop && (r_count != '0);

    always_comb begin
        n_wr    = r_wr;
        n_rd    = r_rd;
        n_count = r_count;
        if (do_push) begin
            n_wr = (r_wr == PtrW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
        end
        if (do_pop) begin
            n_rd = (r_rd == PtrW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
        end
        if (do_push && !do_pop) begin
            n_count = r_count + 1'b1;
        end else if (do_pop && !do_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    assign o_data  = r_mem[r_rd];
    assign o_empty = (r_count == '0);
    assign o_full  = (r_count >= CntW'(DEPTH - SLACK));

endmodule

### rtl/fdma_front.sv
module fdma_front #(
    parameter int MAX_FRAME_PIXELS = fdma_pkg::MAX_FRAME_PIXELS_DEF,
    parameter int COORD_BITS       = fdma_pkg::COORD_BITS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_accept,
    input  fdma_pkg::t_in_item                  i_item,
    input  logic                                i_restart,
    input  logic [fdma_pkg::FRAME_DIM_W-1:0]    i_frame_width,
    input  logic [fdma_pkg::FRAME_DIM_W-1:0]    i_frame_height,
    input  logic [fdma_pkg::WINDOW_HALF_W-1:0]  i_window_half,
    output fdma_pkg::t_token                    o_tok,
    output logic                                o_store,
    output logic [$clog2(MAX_FRAME_PIXELS)-1:0] o_addr
);

    localparam int AddrW = $clog2(MAX_FRAME_PIXELS);
    localparam int DimW  = (COORD_BITS + 1 > fdma_pkg::FRAME_DIM_W) ?
                           COORD_BITS + 1 : fdma_pkg::FRAME_DIM_W;
    localparam int IdxW  = (2 * (COORD_BITS + 1) > AddrW + 1) ?
                           2 * (COORD_BITS + 1) : AddrW + 1;
    localparam int SumW  = ((COORD_BITS > fdma_pkg::WINDOW_HALF_W) ?
                           COORD_BITS : fdma_pkg::WINDOW_HALF_W) + 2;

    logic [COORD_BITS-1:0] r_col, r_row, n_col, n_row;
    logic [IdxW-1:0]       r_idx, n_idx;
    logic                  r_ref_valid, n_ref_valid;

    logic [DimW-1:0]       w_dim, h_dim, dim_top;
    logic [COORD_BITS:0]   w, h;
    logic [SumW-1:0]       x_s, y_s, mx_s, my_s, hw_s;
    logic                  col_last, row_last, last, idx_ok, x_in, y_in;
    logic                  is_pixel;

    function automatic logic [DimW-1:0] clamp_dim(input logic [DimW-1:0] v,
                                                  input logic [DimW-1:0] top);
        logic [DimW-1:0] res;
        res = v;
        if (v < DimW'(2)) begin
            res = DimW'(2);
        end else if (v > top) begin
            res = top;
        end
        return res;
    endfunction

    assign dim_top = DimW'(1) << COORD_BITS;
    assign w_dim   = clamp_dim(DimW'(i_frame_width), dim_top);
    assign h_dim   = clamp_dim(DimW'(i_frame_height), dim_top);
    assign w       = w_dim[COORD_BITS:0];
    assign h       = h_dim[COORD_BITS:0];

    assign col_last = ({1'b0, r_col} == w - 1'b1);
    assign row_last = ({1'b0, r_row} == h - 1'b1);
    assign last     = col_last && row_last;
    assign idx_ok   = (r_idx < IdxW'(MAX_FRAME_PIXELS));

    assign x_s  = SumW'(r_col);
    assign y_s  = SumW'(r_row);
    assign mx_s = SumW'(w >> 1);
    assign my_s = SumW'(h >> 1);
    assign hw_s = SumW'(i_window_half);
    assign x_in = (x_s + hw_s >= mx_s) && (x_s < mx_s + hw_s);
    assign y_in = (y_s + hw_s >= my_s) && (y_s < my_s + hw_s);

    assign is_pixel = (i_item.cmd == fdma_pkg::CMD_PIXEL);

    always_comb begin
        o_tok.gray_level = i_item.gray_level;
        o_tok.silence    = !is_pixel;
        o_tok.check      = is_pixel && idx_ok && r_ref_valid && x_in && y_in;
        o_tok.last       = is_pixel && last;
        o_tok.report     = is_pixel && last && r_ref_valid;
        o_store          = is_pixel && idx_ok;
        o_addr           = r_idx[AddrW-1:0];
    end

    always_comb begin
        n_col       = r_col;
        n_row       = r_row;
        n_idx       = r_idx;
        n_ref_valid = r_ref_valid;
        if (i_restart) begin
            n_col       = '0;
            n_row       = '0;
            n_idx       = '0;
            n_ref_valid = 1'b0;
        end else if (i_accept && is_pixel) begin
            if (col_last) begin
                n_col = '0;
                n_row = row_last ? '0 : r_row + 1'b1;
            end else begin
                n_col = r_col + 1'b1;
            end
            n_idx = last ? '0 : r_idx + 1'b1;
            if (last) begin
                n_ref_valid = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col       <= '0;
            r_row       <= '0;
            r_idx       <= '0;
            r_ref_valid <= 1'b0;
        end else begin
            r_col       <= n_col;
            r_row       <= n_row;
            r_idx       <= n_idx;
            r_ref_valid <= n_ref_valid;
        end
    end

endmodule

### rtl/fdma_store.sv
module fdma_store #(
    parameter int MAX_FRAME_PIXELS = fdma_pkg::MAX_FRAME_PIXELS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_issue,
    input  fdma_pkg::t_token                    i_tok,
    input  logic                                i_store,
    input  logic [$clog2(MAX_FRAME_PIXELS)-1:0] i_addr,
    output logic                                o_valid,
    output fdma_pkg::t_work                     o_work
);

    logic [fdma_pkg::PIXEL_W-1:0] r_frame [MAX_FRAME_PIXELS];
    logic [fdma_pkg::PIXEL_W-1:0] r_old;
    fdma_pkg::t_token             r_tok;
    logic                         r_valid;

    always_ff @(posedge i_clk) begin
        if (i_issue) begin
            r_old <= r_frame[i_addr];
            r_tok <= i_tok;
            if (i_store) begin
                r_frame[i_addr] <= i_tok.gray_level;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_issue;
        end
    end

    assign o_valid          = r_valid;
    assign o_work.tok       = r_tok;
    assign o_work.old_level = r_old;

endmodule

### rtl/fdma_back.sv
module fdma_back (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_restart,
    input  logic [fdma_pkg::THRESHOLD_W-1:0]  i_diff_threshold,
    input  logic                              i_work_empty,
    input  fdma_pkg::t_work                   i_work,
    output logic                              o_work_pop,
    input  logic                              i_res_full,
    output logic                              o_res_push,
    output fdma_pkg::t_out_item               o_res
);

    logic [fdma_pkg::PIXEL_W-1:0] diff;
    logic                         take, hit, motion_now;
    logic                         r_motion_seen, n_motion_seen;
    logic                         r_alarm, n_alarm;

    assign take = !i_work_empty && !i_res_full;
    assign diff = (i_work.tok.gray_level > i_work.old_level) ?
                  i_work.tok.gray_level - i_work.old_level :
                  i_work.old_level - i_work.tok.gray_level;
    assign hit        = i_work.tok.check && (diff > i_diff_threshold);
    assign motion_now = r_motion_seen || hit;

    always_comb begin
        n_motion_seen       = r_motion_seen;
        n_alarm             = r_alarm;
        o_res_push          = 1'b0;
        o_res.motion        = motion_now;
        o_res.alarm_on      = r_alarm || motion_now;
        o_res.alarm_started = motion_now && !r_alarm;
        if (i_restart) begin
            n_motion_seen = 1'b0;
        end else if (take) begin
            if (i_work.tok.silence) begin
                n_alarm = 1'b0;
            end else if (i_work.tok.report) begin
                o_res_push    = 1'b1;
                n_alarm       = r_alarm || motion_now;
                n_motion_seen = 1'b0;
            end else if (i_work.tok.last) begin
                n_motion_seen = 1'b0;
            end else begin
                n_motion_seen = motion_now;
            end
        end
    end

    assign o_work_pop = take;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_motion_seen <= 1'b0;
            r_alarm       <= 1'b0;
        end else begin
            r_motion_seen <= n_motion_seen;
            r_alarm       <= n_alarm;
        end
    end

endmodule
